// ----- hw/rtl/pmu_pkg.sv -----
package pmu_pkg;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIVOT_X     = 3'd0,
    REG_PIVOT_Y     = 3'd1,
    REG_PIVOT_Z     = 3'd2,
    REG_LOOP_ENABLE = 3'd3,
    REG_MOTION_MODE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        age;
    logic [30:0]        life_span;
    logic [30:0]        speed;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic [30:0]        time_step;
    logic               last_particle;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic [30:0]        new_age;
    logic               restarted;
    logic               last_out;
  } out_item_t;

  typedef struct packed {
    logic [2:0][31:0] pivot;
    logic             loop_enable;
    logic             motion_mode;
  } cfg_t;

  // one pipeline slot, fields unused by later stages are trimmed by synthesis
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] start;
    logic [31:0]      m;
    logic [30:0]      age;
    logic             restart;
    logic             last;
    logic             spread;
    logic [2:0]       neg;
    logic [2:0][32:0] ea;
    logic [2:0][19:0] e;
    logic [2:0][39:0] sq;
    logic [33:0]      rem;
    logic [30:0]      root;
    logic [61:0]      xs;
    logic [2:0][31:0] dr;
    logic [2:0][16:0] dq;
    logic [2:0][32:0] mv;
  } slot_t;

endpackage

// ----- hw/rtl/particle_motion_update_core.sv -----
// each request passes through the pipeline stages in order, from input request to result
// throughput: one request per cycle; the 31-stage square root and the
// 17-stage dividers are fully pipelined, so only output stall slows it
// a stalled result freezes the whole pipeline, nothing is lost or repeated
// reset (rst, synchronous): clears all valid bits and the config registers
module particle_motion_update_core
  import pmu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int S_NORM  = 1;
  localparam int S_SQ    = 2;
  localparam int S_SUM   = 3;
  localparam int S_SQRT0 = 4;
  localparam int N_SQRT  = 31;
  localparam int S_DIV0  = S_SQRT0 + N_SQRT;
  localparam int N_DIV   = 17;
  localparam int S_MUL   = S_DIV0 + N_DIV;
  localparam int S_OUT   = S_MUL + 1;
  localparam int NST     = S_OUT + 1;

  cfg_t  cfg;
  slot_t st [NST];
  slot_t st_next [NST];
  logic [NST-1:0] vld;
  logic en;

  assign cfg_ready = 1'b1;
  assign en        = !(vld[NST-1] && out_stall);
  assign in_stall  = vld[NST-1] && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PIVOT_X:     cfg.pivot[0] <= cfg_data;
        REG_PIVOT_Y:     cfg.pivot[1] <= cfg_data;
        REG_PIVOT_Z:     cfg.pivot[2] <= cfg_data;
        REG_LOOP_ENABLE: cfg.loop_enable <= cfg_data[0];
        REG_MOTION_MODE: cfg.motion_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'h7fffffff;
    if (v < -34'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic slot_t entry(input in_item_t d, input cfg_t c);
    slot_t s;
    logic signed [32:0] df;
    logic [61:0] prod;
    logic [31:0] ag;
    s = '0;
    s.pos   = {d.pos_z, d.pos_y, d.pos_x};
    s.start = {d.start_z, d.start_y, d.start_x};
    for (int i = 0; i < 3; i++) begin
      df = $signed({s.pos[i][31], s.pos[i]}) - $signed({c.pivot[i][31], c.pivot[i]});
      s.neg[i] = df[32];
      s.ea[i]  = df[32] ? 33'(-df) : 33'(df);
    end
    prod = 62'(d.speed) * 62'(d.time_step);
    s.m  = (prod[61:48] != '0) ? 32'hffffffff : prod[47:16];
    ag   = 32'(d.age) + 32'(d.time_step);
    s.age     = ag[31] ? 31'h7fffffff : ag[30:0];
    s.restart = c.loop_enable && (s.age >= d.life_span);
    s.last    = d.last_particle;
    s.spread  = !c.motion_mode;
    return s;
  endfunction

  function automatic slot_t stage_fn(input int k, input slot_t p);
    slot_t s;
    logic [32:0] a;
    logic [3:0]  sh;
    logic [33:0] r;
    logic [32:0] trial;
    logic [32:0] t;
    logic [48:0] pm;
    logic signed [33:0] v;
    s = p;
    a = '0; sh = '0; r = '0; trial = '0; t = '0; pm = '0; v = '0;
    if (k == S_NORM) begin
      for (int i = 0; i < 3; i++) if (p.ea[i] > a) a = p.ea[i];
      sh = 4'd13;
      for (int j = 13; j >= 0; j--) if ((a >> j) < 33'h100000) sh = 4'(j);
      for (int i = 0; i < 3; i++) s.e[i] = 20'(p.ea[i] >> sh);
      if (!p.spread)
        s.pos[1] = sat32($signed({{2{p.pos[1][31]}}, p.pos[1]}) - $signed({2'b00, p.m}));
    end else if (k == S_SQ) begin
      for (int i = 0; i < 3; i++) s.sq[i] = 40'(p.e[i]) * 40'(p.e[i]);
    end else if (k == S_SUM) begin
      s.xs   = {42'(p.sq[0]) + 42'(p.sq[1]) + 42'(p.sq[2]), 20'b0};
      s.rem  = '0;
      s.root = '0;
    end else if (k >= S_SQRT0 && k < S_DIV0) begin
      r     = {p.rem[31:0], p.xs[61:60]};
      trial = {p.root, 2'b01};
      if (r >= 34'(trial)) begin
        s.rem  = r - 34'(trial);
        s.root = {p.root[29:0], 1'b1};
      end else begin
        s.rem  = r;
        s.root = {p.root[29:0], 1'b0};
      end
      s.xs = {p.xs[59:0], 2'b00};
    end else if (k >= S_DIV0 && k < S_MUL) begin
      for (int i = 0; i < 3; i++) begin
        // numerator is e << 26, its low bits are zero
        t = (k == S_DIV0) ? {3'b000, p.e[i], 10'b0} : {p.dr[i], 1'b0};
        if (t >= 33'(p.root)) begin
          t = t - 33'(p.root);
          s.dq[i] = {p.dq[i][15:0], 1'b1};
        end else begin
          s.dq[i] = {p.dq[i][15:0], 1'b0};
        end
        s.dr[i] = t[31:0];
      end
    end else if (k == S_MUL) begin
      for (int i = 0; i < 3; i++) begin
        pm = 49'(p.m) * 49'(p.dq[i]);
        s.mv[i] = pm[48:16];
      end
    end else if (k == S_OUT) begin
      for (int i = 0; i < 3; i++) begin
        if (p.restart) begin
          s.pos[i] = p.start[i];
        end else if (p.spread && p.root != '0) begin
          v = p.neg[i] ? $signed({{2{p.pos[i][31]}}, p.pos[i]}) - $signed({1'b0, p.mv[i]})
                       : $signed({{2{p.pos[i][31]}}, p.pos[i]}) + $signed({1'b0, p.mv[i]});
          s.pos[i] = sat32(v);
        end
      end
      if (p.restart) s.age = '0;
    end
    return s;
  endfunction

  always_comb begin
    st_next[0] = entry(in_data, cfg);
    for (int k = 1; k < NST; k++) st_next[k] = stage_fn(k, st[k-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NST; k++) st[k] <= st_next[k];
    end
  end

  assign out_valid          = vld[NST-1];
  assign out_data.new_x     = st[NST-1].pos[0];
  assign out_data.new_y     = st[NST-1].pos[1];
  assign out_data.new_z     = st[NST-1].pos[2];
  assign out_data.new_age   = st[NST-1].age;
  assign out_data.restarted = st[NST-1].restart;
  assign out_data.last_out  = st[NST-1].last;

  a_restart_age: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.restarted |-> out_data.new_age == '0)
    else $error("restarted particle with non-zero age");

  a_no_loop: assert property (@(posedge clk) disable iff (rst)
    vld[S_NORM] && !cfg.loop_enable |-> !st[S_NORM].restart)
    else $error("restart flagged with looping off");

  a_sqrt_floor: assert property (@(posedge clk) disable iff (rst)
    vld[S_DIV0-1] |-> st[S_DIV0-1].rem <= 34'({st[S_DIV0-1].root, 1'b0}))
    else $error("square root remainder out of range");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    en && vld[S_MUL] |=> vld[S_OUT])
    else $error("item lost between multiply and output stage");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved while output stalled");

endmodule
